// ===== hw/rtl/format_spec_parser_core_assert.svh =====
// Assertion shorthands: sampled on clk, off while rst_n is low.
`ifndef FORMAT_SPEC_PARSER_CORE_ASSERT_SVH
`define FORMAT_SPEC_PARSER_CORE_ASSERT_SVH

// Same-cycle implication.
`define FSP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/fsp_pkg.sv =====
`default_nettype none

package fsp_pkg;

    typedef logic [7:0] char_t;

    typedef enum logic [2:0] {
        PH_FLAGS = 3'd0,
        PH_WIDTH = 3'd1,
        PH_WDIG  = 3'd2,
        PH_WSTAR = 3'd3,
        PH_PREC  = 3'd4,
        PH_PDOT  = 3'd5,
        PH_PDIG  = 3'd6,
        PH_TYPE  = 3'd7
    } phase_t;

    typedef enum logic [3:0] {
        CONV_D   = 4'd0,
        CONV_S   = 4'd1,
        CONV_C   = 4'd2,
        CONV_PCT = 4'd3,
        CONV_I   = 4'd4,
        CONV_P   = 4'd5,
        CONV_X   = 4'd6,
        CONV_XU  = 4'd7,
        CONV_U   = 4'd8
    } conv_t;

    // ASCII codes
    localparam char_t CH_MINUS = 8'h2D;
    localparam char_t CH_ZERO  = 8'h30;
    localparam char_t CH_ONE   = 8'h31;
    localparam char_t CH_NINE  = 8'h39;
    localparam char_t CH_SPACE = 8'h20;
    localparam char_t CH_HASH  = 8'h23;
    localparam char_t CH_PLUS  = 8'h2B;
    localparam char_t CH_DOT   = 8'h2E;
    localparam char_t CH_STAR  = 8'h2A;
    localparam char_t CH_PCT   = 8'h25;
    localparam char_t CH_LC_D  = 8'h64;
    localparam char_t CH_LC_S  = 8'h73;
    localparam char_t CH_LC_C  = 8'h63;
    localparam char_t CH_LC_I  = 8'h69;
    localparam char_t CH_LC_P  = 8'h70;
    localparam char_t CH_LC_X  = 8'h78;
    localparam char_t CH_UC_X  = 8'h58;
    localparam char_t CH_LC_U  = 8'h75;

    // flag bit positions
    localparam int unsigned FLAG_MINUS = 0;
    localparam int unsigned FLAG_ZERO  = 1;
    localparam int unsigned FLAG_SPACE = 2;
    localparam int unsigned FLAG_HASH  = 3;
    localparam int unsigned FLAG_PLUS  = 4;
    localparam int unsigned FLAG_W     = 5;

    localparam int unsigned WIDTH_W = 31;
    localparam int unsigned PREC_W  = 32;

    localparam logic [WIDTH_W-1:0]       SAT_MAX   = '1;
    localparam logic signed [PREC_W-1:0] PREC_NONE = -32'sd1;

    typedef struct packed {
        phase_t                    phase;
        logic                      matched;
        logic [FLAG_W-1:0]         flags;
        logic [WIDTH_W-1:0]        width;
        logic signed [PREC_W-1:0]  prec;
    } spec_state_t;

    typedef struct packed {
        conv_t                     conv;
        logic signed [PREC_W-1:0]  prec;
        logic [WIDTH_W-1:0]        width;
        logic [FLAG_W-1:0]         flags;
    } spec_result_t;

    localparam spec_state_t STATE_RESET = '{
        phase:   PH_FLAGS,
        matched: 1'b0,
        flags:   '0,
        width:   '0,
        prec:    PREC_NONE
    };

    function automatic logic [FLAG_W-1:0] flag_of(char_t c);
        logic [FLAG_W-1:0] f;
        f = '0;
        unique case (c)
            CH_MINUS: f[FLAG_MINUS] = 1'b1;
            CH_ZERO:  f[FLAG_ZERO]  = 1'b1;
            CH_SPACE: f[FLAG_SPACE] = 1'b1;
            CH_HASH:  f[FLAG_HASH]  = 1'b1;
            CH_PLUS:  f[FLAG_PLUS]  = 1'b1;
            default:  f = '0;
        endcase
        return f;
    endfunction

    function automatic logic is_digit(char_t c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_lead_digit(char_t c);
        return (c >= CH_ONE) && (c <= CH_NINE);
    endfunction

    function automatic logic is_conv(char_t c);
        return (c == CH_LC_D) || (c == CH_LC_S) || (c == CH_LC_C) || (c == CH_PCT) ||
               (c == CH_LC_I) || (c == CH_LC_P) || (c == CH_LC_X) || (c == CH_UC_X) ||
               (c == CH_LC_U);
    endfunction

    function automatic conv_t conv_of(char_t c);
        conv_t cv;
        unique case (c)
            CH_LC_D: cv = CONV_D;
            CH_LC_S: cv = CONV_S;
            CH_LC_C: cv = CONV_C;
            CH_PCT:  cv = CONV_PCT;
            CH_LC_I: cv = CONV_I;
            CH_LC_P: cv = CONV_P;
            CH_LC_X: cv = CONV_X;
            CH_UC_X: cv = CONV_XU;
            CH_LC_U: cv = CONV_U;
            default: cv = CONV_D;
        endcase
        return cv;
    endfunction

    // digit value: low nibble of an ASCII decimal digit
    function automatic logic [3:0] digit_val(char_t c);
        return c[3:0];
    endfunction

    // v*10 + digit, saturating (v*10 as v<<3 + v<<1)
    function automatic logic [WIDTH_W-1:0] push_digit(logic [WIDTH_W-1:0] v, char_t c);
        logic [WIDTH_W+3:0] n;
        n = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {{WIDTH_W{1'b0}}, digit_val(c)};
        return (n > {4'b0000, SAT_MAX}) ? SAT_MAX : n[WIDTH_W-1:0];
    endfunction

    // magnitude of a star width; most negative value saturates
    function automatic logic [WIDTH_W-1:0] star_width(logic signed [PREC_W-1:0] v);
        logic [PREC_W-1:0] inv;
        logic [PREC_W-1:0] mag;
        inv = ~v;
        mag = inv + 32'd1;
        if (!v[PREC_W-1])
            return v[WIDTH_W-1:0];
        else if (mag[PREC_W-1])
            return SAT_MAX;
        else
            return mag[WIDTH_W-1:0];
    endfunction

    // does the round, entered at this phase, consume the character?
    function automatic logic phase_takes(phase_t ph, char_t c);
        logic t;
        unique case (ph)
            PH_FLAGS: t = (flag_of(c) != '0) || is_lead_digit(c) || (c == CH_STAR) ||
                          (c == CH_DOT);
            PH_WIDTH: t = is_lead_digit(c) || (c == CH_STAR) || (c == CH_DOT);
            PH_WDIG:  t = is_digit(c) || (c == CH_STAR) || (c == CH_DOT);
            PH_WSTAR: t = (c == CH_STAR) || (c == CH_DOT);
            PH_PREC:  t = (c == CH_DOT);
            PH_PDOT:  t = (c == CH_STAR) || is_digit(c);
            PH_PDIG:  t = is_digit(c);
            PH_TYPE:  t = 1'b0;
            default:  t = 1'b0;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fsp_step.sv =====
`default_nettype none

// One character through the round phases, including the one allowed restart.
module fsp_step (
    input  wire fsp_pkg::spec_state_t        cur,
    input  wire fsp_pkg::char_t              ch,
    input  wire logic signed [31:0]          star_value,
    output fsp_pkg::spec_state_t             nxt,
    output logic                             emit,
    output fsp_pkg::spec_result_t            res
);

    fsp_pkg::phase_t                    p_eff;
    fsp_pkg::phase_t                    phase_next;
    logic                               restart;
    logic                               pdot_fall;
    logic                               hit;
    logic                               star_c;
    logic                               dot_c;
    logic                               dig_c;
    logic                               lead_c;
    logic [fsp_pkg::FLAG_W-1:0]         flag_c;
    logic                               h_flag;
    logic                               h_wnz;
    logic                               h_wdig;
    logic                               h_wstar;
    logic                               h_dot;
    logic                               h_pstar;
    logic                               h_pfirst;
    logic                               h_pdig;
    logic                               matched_next;
    logic [fsp_pkg::FLAG_W-1:0]         flags_next;
    logic [fsp_pkg::WIDTH_W-1:0]        width_next;
    logic signed [fsp_pkg::PREC_W-1:0]  prec_next;
    logic signed [fsp_pkg::PREC_W-1:0]  prec_cur;

    assign star_c = (ch == fsp_pkg::CH_STAR);
    assign dot_c  = (ch == fsp_pkg::CH_DOT);
    assign dig_c  = fsp_pkg::is_digit(ch);
    assign lead_c = fsp_pkg::is_lead_digit(ch);
    assign flag_c = fsp_pkg::flag_of(ch);

    // a dot with neither star nor digits means precision zero
    assign pdot_fall = (cur.phase == fsp_pkg::PH_PDOT) && !star_c && !dig_c;
    assign prec_cur  = pdot_fall ? '0 : cur.prec;

    // unmatched conversion slot after a productive round: rerun from flags once
    assign restart = !fsp_pkg::phase_takes(cur.phase, ch) && !fsp_pkg::is_conv(ch) &&
                     cur.matched;
    assign p_eff   = restart ? fsp_pkg::PH_FLAGS : cur.phase;

    assign h_flag   = (p_eff == fsp_pkg::PH_FLAGS) && (flag_c != '0);
    assign h_wnz    = ((p_eff == fsp_pkg::PH_FLAGS) || (p_eff == fsp_pkg::PH_WIDTH)) && lead_c;
    assign h_wdig   = (p_eff == fsp_pkg::PH_WDIG) && dig_c;
    assign h_wstar  = ((p_eff == fsp_pkg::PH_FLAGS) || (p_eff == fsp_pkg::PH_WIDTH) ||
                       (p_eff == fsp_pkg::PH_WDIG)  || (p_eff == fsp_pkg::PH_WSTAR)) && star_c;
    assign h_dot    = ((p_eff == fsp_pkg::PH_FLAGS) || (p_eff == fsp_pkg::PH_WIDTH) ||
                       (p_eff == fsp_pkg::PH_WDIG)  || (p_eff == fsp_pkg::PH_WSTAR) ||
                       (p_eff == fsp_pkg::PH_PREC)) && dot_c;
    assign h_pstar  = (p_eff == fsp_pkg::PH_PDOT) && star_c;
    assign h_pfirst = (p_eff == fsp_pkg::PH_PDOT) && dig_c;
    assign h_pdig   = (p_eff == fsp_pkg::PH_PDIG) && dig_c;

    assign hit = h_flag | h_wnz | h_wdig | h_wstar | h_dot | h_pstar | h_pfirst | h_pdig;

    // next phase
    always_comb
    begin
        unique if (h_flag)
            phase_next = fsp_pkg::PH_WIDTH;
        else if (h_wnz || h_wdig || h_pfirst || h_pdig)
            phase_next = (h_pfirst || h_pdig) ? fsp_pkg::PH_PDIG : fsp_pkg::PH_WDIG;
        else if (h_wstar)
            phase_next = fsp_pkg::PH_PREC;
        else if (h_dot)
            phase_next = fsp_pkg::PH_PDOT;
        else if (h_pstar)
            phase_next = fsp_pkg::PH_TYPE;
        else
            phase_next = fsp_pkg::PH_FLAGS;
    end

    // outputs: result and datapath updates
    always_comb
    begin
        emit = !hit && fsp_pkg::is_conv(ch);

        res.conv  = fsp_pkg::conv_of(ch);
        res.prec  = prec_cur;
        res.width = cur.width;
        res.flags = cur.flags;

        flags_next   = cur.flags;
        width_next   = cur.width;
        prec_next    = prec_cur;
        matched_next = 1'b0;

        if (emit)
        begin
            flags_next = fsp_pkg::STATE_RESET.flags;
            width_next = fsp_pkg::STATE_RESET.width;
            prec_next  = fsp_pkg::STATE_RESET.prec;
        end
        else
        begin
            if (h_flag || h_wnz || h_wstar || h_dot)
                matched_next = 1'b1;
            else if (hit)
                matched_next = cur.matched;

            if (h_flag)
                flags_next = cur.flags | flag_c;
            if (h_wnz)
                width_next = {{(fsp_pkg::WIDTH_W-4){1'b0}}, fsp_pkg::digit_val(ch)};
            if (h_wdig)
                width_next = fsp_pkg::push_digit(cur.width, ch);
            if (h_wstar)
            begin
                width_next = fsp_pkg::star_width(star_value);
                if (star_value[31])
                    flags_next[fsp_pkg::FLAG_MINUS] = 1'b1;
            end
            if (h_pstar)
                prec_next = (star_value < fsp_pkg::PREC_NONE) ? fsp_pkg::PREC_NONE : star_value;
            if (h_pfirst)
                prec_next = {{(fsp_pkg::PREC_W-4){1'b0}}, fsp_pkg::digit_val(ch)};
            if (h_pdig)
                prec_next = {1'b0, fsp_pkg::push_digit(cur.prec[fsp_pkg::WIDTH_W-1:0], ch)};
        end
    end

    assign nxt.phase   = phase_next;
    assign nxt.matched = matched_next;
    assign nxt.flags   = flags_next;
    assign nxt.width   = width_next;
    assign nxt.prec    = prec_next;

endmodule

`default_nettype wire

// ===== hw/rtl/fsp_out_reg.sv =====
`default_nettype none

// Result register on the master side.
module fsp_out_reg (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          load,
    input  wire fsp_pkg::spec_result_t   res,
    output logic                         free,
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [71:0]                  m_tdata
);

    logic                   valid_reg;
    logic                   valid_next;
    fsp_pkg::spec_result_t  data_reg;

    assign free       = !valid_reg || m_tready;
    assign valid_next = load || (valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= res;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/format_spec_parser_core.sv =====
// The beat carrying the conversion character is registered in the input register and then in
//   the result register, whose valid drives m_tvalid.
// Throughput: one character beat per cycle while no result is held back. A
//   conversion character waits in the input register while a result beat is unaccepted.
// Reset (rst_n low, asynchronous): both stage valids clear and the parser returns to
//   the flags phase with no flags, zero width and no precision.
`default_nettype none
`include "format_spec_parser_core_assert.svh"

module format_spec_parser_core (
    input  wire          clk,
    input  wire          rst_n,
    // input channel: one format character per beat
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [39:0]  s_tdata,   // [7:0] ch, [39:8] star_value
    // result channel: one parsed specifier per beat
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [71:0]  m_tdata    // [0] left_align, [1] zero_pad, [2] space_sign,
                                    // [3] alt_form, [4] plus_sign, [35:5] field_width,
                                    // [67:36] precision_out, [71:68] conversion
);

    // input register stage
    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    fsp_pkg::char_t         s1_ch_reg;
    logic signed [31:0]     s1_star_reg;
    logic                   s1_fire;
    logic                   s_accept;

    // parser state
    fsp_pkg::spec_state_t   st_reg;
    fsp_pkg::spec_state_t   st_next;
    fsp_pkg::spec_state_t   st_step;

    logic                   emit;
    logic                   out_free;
    fsp_pkg::spec_result_t  res;

    // a staged character retires unless it produces a result that cannot land
    assign s1_fire       = s1_valid_reg && (!emit || out_free);
    assign s_tready      = !s1_valid_reg || s1_fire;
    assign s_accept      = s_tvalid && s_tready;
    assign s1_valid_next = s_accept || (s1_valid_reg && !s1_fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_ch_reg   <= s_tdata[7:0];
            s1_star_reg <= s_tdata[39:8];
        end
    end

    fsp_step u_step (
        .cur        (st_reg),
        .ch         (s1_ch_reg),
        .star_value (s1_star_reg),
        .nxt        (st_step),
        .emit       (emit),
        .res        (res)
    );

    // state advances only when the staged character retires
    assign st_next = s1_fire ? st_step : st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= fsp_pkg::STATE_RESET;
        else
            st_reg <= st_next;
    end

    fsp_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (s1_fire && emit),
        .res      (res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // a delivered specifier leaves the parser clean for the next one
    `FSP_ASSERT_NEXT(a_clear_after_emit, s1_fire && emit, st_reg == fsp_pkg::STATE_RESET, "state not cleared after conversion")
    // an emitted specifier is always presented on the next cycle
    `FSP_ASSERT_NEXT(a_emit_lands, s1_fire && emit, m_tvalid, "result beat lost")
    // precision never drops below the "none" marker
    `FSP_ASSERT_NOW(a_prec_floor, st_reg.prec[31], st_reg.prec == fsp_pkg::PREC_NONE, "precision below -1")
    // width digits always start from a nonzero lead digit
    `FSP_ASSERT_NOW(a_wdig_nonzero, st_reg.phase == fsp_pkg::PH_WDIG, st_reg.width != '0, "zero width in digit phase")

endmodule

`default_nettype wire
